// ===== rtl/core/c2dvs_pkg.sv =====
package c2dvs_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int COEF_BITS  = 16;
  localparam int PROD_BITS  = PIXEL_BITS + COEF_BITS;
  localparam int ACC_BITS   = 32;
  localparam int SHIFT_BITS = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIV_BITS   = 7;
  localparam int ROW_BITS   = 12;
  localparam int COL_BITS   = 8;
  localparam int MAP_BITS   = 16;

  // request codes
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // register indexes
  localparam logic [2:0] REG_IMG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_IMG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_KER_ROWS      = 3'd2;
  localparam logic [2:0] REG_KER_COLS      = 3'd3;
  localparam logic [2:0] REG_SCALE_DIVISOR = 3'd4;

  typedef struct packed {
    logic                         req_type;
    logic [6:0]                   coef_index;
    logic signed [COEF_BITS-1:0]  coef_value;
    logic signed [PIXEL_BITS-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic signed [MAP_BITS-1:0] map_value;
    logic [ROW_BITS-1:0]        out_row;
    logic [COL_BITS-1:0]        out_col;
    logic                       frame_last;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/c2dvs_mac.sv =====
module c2dvs_mac (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  c2dvs_pkg::mac_ctl_t                      ctl,
  input  logic signed [c2dvs_pkg::PIXEL_BITS-1:0]  pix,
  input  logic signed [c2dvs_pkg::COEF_BITS-1:0]   coef,
  output logic                                     busy,
  output logic [c2dvs_pkg::ACC_BITS-1:0]           acc
);

  logic signed [c2dvs_pkg::PROD_BITS-1:0] mul;
  logic [c2dvs_pkg::ACC_BITS-1:0] prod_r, prod_nxt;
  logic                           prod_v_r, prod_v_nxt;
  logic [c2dvs_pkg::ACC_BITS-1:0] acc_r, acc_nxt;

  always_comb begin
    mul        = pix * coef;
    prod_nxt   = mul[c2dvs_pkg::ACC_BITS-1:0];
    prod_v_nxt = ctl.en & ~ctl.clr;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + prod_r;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      prod_r   <= '0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= prod_v_nxt;
      prod_r   <= prod_nxt;
      acc_r    <= acc_nxt;
    end
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/core/c2dvs_div.sv =====
module c2dvs_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [c2dvs_pkg::ACC_BITS-1:0]       dividend,
  input  logic [c2dvs_pkg::DIV_BITS-1:0]       divisor,
  output c2dvs_pkg::div_stat_t                 stat,
  output logic [c2dvs_pkg::ACC_BITS-1:0]       quotient
);

  localparam int AW = c2dvs_pkg::ACC_BITS;
  localparam int DW = c2dvs_pkg::DIV_BITS;
  localparam int CNTW = $clog2(AW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic [AW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dvs_r, dvs_nxt;
  logic [AW-1:0]   res_r, res_nxt;
  logic [DW:0]     trial;
  logic            ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    res_nxt  = res_r;
    trial    = {rem_r, quo_r[AW-1]};
    ge       = trial >= {1'b0, dvs_r};
    if (start) begin
      // divide magnitudes, fix sign at the end (truncates toward zero)
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[AW-1];
      quo_nxt  = dividend[AW-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // one quotient bit per cycle
      rem_nxt = ge ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      quo_nxt = {quo_r[AW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(AW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (~{quo_r[AW-2:0], ge} + 1'b1) : {quo_r[AW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
      quo_r  <= '0;
      rem_r  <= '0;
      dvs_r  <= '0;
      res_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      neg_r  <= neg_nxt;
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_nxt;
      res_r  <= res_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = res_r;

endmodule

// ===== rtl/core/conv2d_valid_scaled_core.sv =====
// channel  | ports                          | direction | word
// in       | in_valid in_ready in_data      | into core | coefficient load or pixel
// out      | out_valid out_ready out_data   | from core | scaled result with coordinates
// cfg      | cfg_psel .. cfg_prdata         | into core | register writes and reads
//
// sequence: a coefficient word or a pixel without a full window is taken on its own; a pixel
//   with a window is taken, then its kr*kc taps are read one per cycle through the line and
//   coefficient memory ports, the mac drains, the divider runs its 32 quotient steps and
//   raises done, then the output register is loaded
// reset: after rst_n all MAX_KERNEL*MAX_WIDTH line memory entries (2304 at the defaults) are
//   cleared, with in_ready low; configuration writes are taken meanwhile
// stalls: a finished word waits in the output register while the next input word is taken;
//   the core holds only if a second result is ready before the first was taken
module conv2d_valid_scaled_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  c2dvs_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output c2dvs_pkg::out_word_t  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int KN = MAX_KERNEL * MAX_KERNEL;
  localparam int KA = (KN > 1) ? $clog2(KN) : 1;
  localparam int LD = MAX_KERNEL * MAX_WIDTH;
  localparam int LA = $clog2(LD);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int RB = c2dvs_pkg::ROW_BITS;
  localparam int PB = c2dvs_pkg::PIXEL_BITS;
  localparam int CB = c2dvs_pkg::COEF_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_TAPS, ST_DRAIN, ST_DIV, ST_OUT
  } state_t;

  // configuration registers
  logic [8:0]  wid_r;
  logic [12:0] hgt_r;
  logic [3:0]  kr_r, kc_r;
  logic [6:0]  sdiv_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r  <= 9'd256;
      hgt_r  <= 13'd256;
      kr_r   <= 4'd3;
      kc_r   <= 4'd3;
      sdiv_r <= 7'd9;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        c2dvs_pkg::REG_IMG_WIDTH:     wid_r  <= cfg_pwdata[8:0];
        c2dvs_pkg::REG_IMG_HEIGHT:    hgt_r  <= cfg_pwdata[12:0];
        c2dvs_pkg::REG_KER_ROWS:      kr_r   <= cfg_pwdata[3:0];
        c2dvs_pkg::REG_KER_COLS:      kc_r   <= cfg_pwdata[3:0];
        c2dvs_pkg::REG_SCALE_DIVISOR: sdiv_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      c2dvs_pkg::REG_IMG_WIDTH:     cfg_prdata = {23'd0, wid_r};
      c2dvs_pkg::REG_IMG_HEIGHT:    cfg_prdata = {19'd0, hgt_r};
      c2dvs_pkg::REG_KER_ROWS:      cfg_prdata = {28'd0, kr_r};
      c2dvs_pkg::REG_KER_COLS:      cfg_prdata = {28'd0, kc_r};
      c2dvs_pkg::REG_SCALE_DIVISOR: cfg_prdata = {25'd0, sdiv_r};
      default:                      cfg_prdata = '0;
    endcase
  end

  // effective geometry: zero reads as one, oversize saturates
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [KW-1:0] kr_eff, kc_eff;
  logic [6:0]    div_eff;

  always_comb begin
    if (wid_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(wid_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wid_r);
    end
    if (hgt_r == '0) begin
      h_eff = 13'd1;
    end else if (int'(hgt_r) > c2dvs_pkg::MAX_HEIGHT) begin
      h_eff = 13'(c2dvs_pkg::MAX_HEIGHT);
    end else begin
      h_eff = hgt_r;
    end
    if (kr_r == '0) begin
      kr_eff = KW'(1);
    end else if (int'(kr_r) > MAX_KERNEL) begin
      kr_eff = KW'(MAX_KERNEL);
    end else begin
      kr_eff = KW'(kr_r);
    end
    if (kc_r == '0) begin
      kc_eff = KW'(1);
    end else if (int'(kc_r) > MAX_KERNEL) begin
      kc_eff = KW'(MAX_KERNEL);
    end else begin
      kc_eff = KW'(kc_r);
    end
    div_eff = (sdiv_r == '0) ? 7'd1 : sdiv_r;
  end

  // sequencer registers
  state_t        state_r, state_nxt;
  logic [LA-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;     // row_r modulo MAX_KERNEL
  logic [KW-1:0] tr_r, tr_nxt, tc_r, tc_nxt;
  logic [KA-1:0] kidx_r, kidx_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt;
  logic [CW-1:0] pc_r, pc_nxt, pc0_r, pc0_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [RB-1:0] orow_r, orow_nxt;
  logic [c2dvs_pkg::COL_BITS-1:0] ocol_r, ocol_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  c2dvs_pkg::out_word_t out_r, out_nxt;

  // current raster position, folded back if geometry shrank
  logic [CW-1:0] c_cur;
  logic [RB-1:0] r_cur;
  logic [SW-1:0] slot_cur, slot_inc, slot_start;
  logic          row_wrap, col_end, row_end, win_ok, frame_end;
  int            orow_i, ocol_i, pcs_i, sst_i;
  logic [LA-1:0] pix_wa, rd_la;

  logic in_fire, is_pixel, is_coef;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign is_pixel = in_fire & (in_data.req_type == c2dvs_pkg::REQ_PIXEL);
  assign is_coef  = in_fire & (in_data.req_type == c2dvs_pkg::REQ_COEF);

  always_comb begin
    c_cur     = (int'(col_r) >= int'(w_eff)) ? '0 : col_r;
    row_wrap  = int'(row_r) >= int'(h_eff);
    r_cur     = row_wrap ? '0 : row_r;
    slot_cur  = row_wrap ? '0 : slot_r;
    slot_inc  = (int'(slot_cur) == MAX_KERNEL - 1) ? '0 : slot_cur + 1'b1;
    col_end   = int'(c_cur) + 1 >= int'(w_eff);
    row_end   = int'(r_cur) + 1 >= int'(h_eff);
    frame_end = (int'(r_cur) + 1 == int'(h_eff)) && (int'(c_cur) + 1 == int'(w_eff));
    win_ok    = (int'(r_cur) + 1 >= int'(kr_eff)) && (int'(c_cur) + 1 >= int'(kc_eff));
    orow_i    = int'(r_cur) - int'(kr_eff) + 1;
    ocol_i    = int'(c_cur) - int'(kc_eff) + 1;
    pcs_i     = ocol_i;
    // top window row slot, wrapping around the ring of rows
    if (int'(slot_cur) >= int'(kr_eff) - 1) begin
      sst_i = int'(slot_cur) - int'(kr_eff) + 1;
    end else begin
      sst_i = int'(slot_cur) + MAX_KERNEL - int'(kr_eff) + 1;
    end
    slot_start = sst_i[SW-1:0];
    pix_wa = LA'(int'(slot_cur) * MAX_WIDTH + int'(c_cur));
    rd_la  = LA'(int'(rslot_r) * MAX_WIDTH + int'(pc_r));
  end

  // line memory: last MAX_KERNEL rows, one row per slot
  logic signed [PB-1:0] line_mem [LD];
  logic signed [PB-1:0] line_q_r;
  logic                 lwe;
  logic [LA-1:0]        lwa;
  logic signed [PB-1:0] lwd;

  assign lwe = (state_r == ST_CLEAR) | is_pixel;
  assign lwa = (state_r == ST_CLEAR) ? clr_addr_r : pix_wa;
  assign lwd = (state_r == ST_CLEAR) ? '0 : in_data.pixel_value;

  always_ff @(posedge clk) begin
    if (lwe) begin
      line_mem[lwa] <= lwd;
    end
    line_q_r <= line_mem[rd_la];
  end

  // coefficient memory, row-major taps
  logic signed [CB-1:0] coef_mem [KN];
  logic signed [CB-1:0] coef_q_r;
  logic                 cwe;

  assign cwe = is_coef & (int'(in_data.coef_index) < KN);

  always_ff @(posedge clk) begin
    if (cwe) begin
      coef_mem[KA'(in_data.coef_index)] <= in_data.coef_value;
    end
    coef_q_r <= coef_mem[kidx_r];
  end

  // multiply-accumulate and divider
  c2dvs_pkg::mac_ctl_t  mac_ctl;
  logic                 mac_busy;
  logic [c2dvs_pkg::ACC_BITS-1:0] mac_acc;
  c2dvs_pkg::div_stat_t div_stat;
  logic [c2dvs_pkg::ACC_BITS-1:0] div_quo;
  logic                 div_start;
  logic signed [c2dvs_pkg::ACC_BITS-1:0] q_sh;

  assign mac_ctl.clr = is_pixel & win_ok;
  assign mac_ctl.en  = rd_v_r;

  c2dvs_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .pix  (line_q_r),
    .coef (coef_q_r),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  c2dvs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(mac_acc),
    .divisor (div_eff),
    .stat    (div_stat),
    .quotient(div_quo)
  );

  // arithmetic shift is a floor, while the divider itself truncates toward zero
  assign q_sh = $signed(div_quo) >>> c2dvs_pkg::SHIFT_BITS;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    tr_nxt        = tr_r;
    tc_nxt        = tc_r;
    kidx_nxt      = kidx_r;
    rslot_nxt     = rslot_r;
    pc_nxt        = pc_r;
    pc0_nxt       = pc0_r;
    rd_v_nxt      = 1'b0;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    div_start     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (int'(clr_addr_r) == LD - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_pixel) begin
          if (col_end) begin
            col_nxt  = '0;
            row_nxt  = row_end ? '0 : r_cur + 1'b1;
            slot_nxt = row_end ? '0 : slot_inc;
          end else begin
            col_nxt  = c_cur + 1'b1;
            row_nxt  = r_cur;
            slot_nxt = slot_cur;
          end
          if (win_ok) begin
            tr_nxt    = '0;
            tc_nxt    = '0;
            kidx_nxt  = '0;
            rslot_nxt = slot_start;
            pc_nxt    = pcs_i[CW-1:0];
            pc0_nxt   = pcs_i[CW-1:0];
            orow_nxt  = orow_i[RB-1:0];
            ocol_nxt  = ocol_i[c2dvs_pkg::COL_BITS-1:0];
            last_nxt  = frame_end;
            state_nxt = ST_TAPS;
          end
        end
      end
      ST_TAPS: begin
        // one tap read per cycle, walking the window row by row
        rd_v_nxt = 1'b1;
        kidx_nxt = kidx_r + 1'b1;
        if (tc_r == kc_eff - 1'b1) begin
          tc_nxt    = '0;
          pc_nxt    = pc0_r;
          tr_nxt    = tr_r + 1'b1;
          rslot_nxt = (int'(rslot_r) == MAX_KERNEL - 1) ? '0 : rslot_r + 1'b1;
          if (tr_r == kr_eff - 1'b1) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          tc_nxt = tc_r + 1'b1;
          pc_nxt = pc_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mac_busy) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.map_value  = q_sh[c2dvs_pkg::MAP_BITS-1:0];
          out_nxt.out_row    = orow_r;
          out_nxt.out_col    = ocol_r;
          out_nxt.frame_last = last_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      tr_r        <= '0;
      tc_r        <= '0;
      kidx_r      <= '0;
      rslot_r     <= '0;
      pc_r        <= '0;
      pc0_r       <= '0;
      rd_v_r      <= 1'b0;
      orow_r      <= '0;
      ocol_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      slot_r      <= slot_nxt;
      tr_r        <= tr_nxt;
      tc_r        <= tc_nxt;
      kidx_r      <= kidx_nxt;
      rslot_r     <= rslot_nxt;
      pc_r        <= pc_nxt;
      pc0_r       <= pc0_nxt;
      rd_v_r      <= rd_v_nxt;
      orow_r      <= orow_nxt;
      ocol_r      <= ocol_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // memory read data is only consumed in the cycle after a tap was issued
  a_rd_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == ST_TAPS))
    else $error("tap data valid without a tap issue");

  // coefficient walk stays inside the kernel store
  a_kidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAPS) |-> (int'(kidx_r) < KN))
    else $error("coefficient index past kernel store");

  // divider is never restarted while busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // a finished divide always moves on to the output stage
  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_stat.done) |=> (state_r == ST_OUT))
    else $error("divide result dropped");
`endif

endmodule
